>>> sv/gap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gap_pkg;

	localparam int unsigned LANES = 8;

	localparam logic [15:0] HALF_QNAN = 16'h7E00;
	localparam logic [14:0] HALF_INF_MAG = 15'h7C00;

	typedef logic [15:0] half_t;
	typedef logic [LANES-1:0][15:0] vec8_t;

	typedef struct packed {
		logic [15:0] lane0;
		logic [15:0] lane1;
		logic [15:0] lane2;
		logic [15:0] lane3;
		logic [15:0] lane4;
		logic [15:0] lane5;
		logic [15:0] lane6;
		logic [15:0] lane7;
	} vec_in_t;

	typedef struct packed {
		logic [15:0] average;
		logic        last_channel;
	} res_out_t;

	typedef struct packed {
		logic [15:0] element_count;
		logic [15:0] scale_factor;
		logic [15:0] clamp_low;
		logic [15:0] clamp_high;
		logic [15:0] channel_count;
	} cfg_t;

	typedef enum logic [2:0] {
		CFG_ELEMENT_COUNT = 3'd0,
		CFG_SCALE_FACTOR  = 3'd1,
		CFG_CLAMP_LOW     = 3'd2,
		CFG_CLAMP_HIGH    = 3'd3,
		CFG_CHANNEL_COUNT = 3'd4
	} cfg_idx_t;

	// what a vector does on its way through the accumulator
	typedef enum logic [1:0] {
		K_HOLD   = 2'd0,
		K_PAIR_A = 2'd1,
		K_PAIR_B = 2'd2,
		K_SINGLE = 2'd3
	} acc_kind_t;

	function automatic logic h_isnan(input logic [15:0] h);
		return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
	endfunction

	function automatic logic h_isinf(input logic [15:0] h);
		return h[14:0] == HALF_INF_MAG;
	endfunction

	function automatic logic h_iszero(input logic [15:0] h);
		return h[14:0] == 15'd0;
	endfunction

	function automatic logic [4:0] lzc14(input logic [13:0] v);
		logic [4:0] z;
		logic       found;
		z = 5'd14;
		found = 1'b0;
		for (int i = 13; i >= 0; i--) begin
			if (!found && v[i]) begin
				z = 5'(13 - i);
				found = 1'b1;
			end
		end
		return z;
	endfunction

	function automatic logic [4:0] lzc22(input logic [21:0] v);
		logic [4:0] z;
		logic       found;
		z = 5'd22;
		found = 1'b0;
		for (int i = 21; i >= 0; i--) begin
			if (!found && v[i]) begin
				z = 5'(21 - i);
				found = 1'b1;
			end
		end
		return z;
	endfunction

	// binary16 add, round to nearest even, 3 extra bits (guard, round, sticky)
	function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] x;
		logic [15:0] y;
		logic [4:0]  ex;
		logic [4:0]  ey;
		logic [10:0] mx;
		logic [10:0] my;
		logic [4:0]  d;
		logic [13:0] xe;
		logic [27:0] yw;
		logic [13:0] ysh;
		logic [14:0] s;
		logic [13:0] n;
		logic [5:0]  e;
		logic [4:0]  z;
		logic [4:0]  sh;
		logic        rnd;
		logic [15:0] pk;
		logic [15:0] r;
		r = 16'd0;
		if (h_isnan(a) || h_isnan(b)) begin
			r = HALF_QNAN;
		end else if (h_isinf(a)) begin
			r = (h_isinf(b) && (a[15] != b[15])) ? HALF_QNAN : a;
		end else if (h_isinf(b)) begin
			r = b;
		end else if (h_iszero(a) && h_iszero(b)) begin
			r = {a[15] & b[15], 15'd0};
		end else begin
			if (a[14:0] >= b[14:0]) begin
				x = a;
				y = b;
			end else begin
				x = b;
				y = a;
			end
			ex = (x[14:10] == 5'd0) ? 5'd1 : x[14:10];
			ey = (y[14:10] == 5'd0) ? 5'd1 : y[14:10];
			mx = {x[14:10] != 5'd0, x[9:0]};
			my = {y[14:10] != 5'd0, y[9:0]};
			d = ex - ey;
			xe = {mx, 3'b000};
			if (d >= 5'd15) begin
				ysh = {13'd0, my != 11'd0};
			end else begin
				yw = {my, 17'd0} >> d;
				ysh = yw[27:14] | {13'd0, yw[13:0] != 14'd0};
			end
			if (x[15] ^ y[15]) begin
				s = {1'b0, xe} - {1'b0, ysh};
			end else begin
				s = {1'b0, xe} + {1'b0, ysh};
			end
			if (s == 15'd0) begin
				r = 16'd0;
			end else begin
				e = {1'b0, ex};
				if (s[14]) begin
					n = s[14:1] | {13'd0, s[0]};
					e = e + 6'd1;
				end else begin
					z = lzc14(s[13:0]);
					sh = (z > (ex - 5'd1)) ? (ex - 5'd1) : z;
					n = s[13:0] << sh;
					e = e - {1'b0, sh};
				end
				rnd = n[2] & (n[1] | n[0] | n[3]);
				if (e >= 6'd31) begin
					r = {x[15], HALF_INF_MAG};
				end else begin
					pk = {1'b0, (n[13] ? e[4:0] : 5'd0), n[12:3]} + {15'd0, rnd};
					r = {x[15], pk[14:0]};
				end
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] h_mul(input logic [15:0] a, input logic [15:0] b);
		logic        sg;
		logic [4:0]  ea;
		logic [4:0]  eb;
		logic [10:0] ma;
		logic [10:0] mb;
		logic [21:0] p;
		logic [4:0]  z;
		logic [21:0] q;
		logic signed [7:0] e;
		logic [6:0]  sh;
		logic [44:0] w;
		logic [21:0] n;
		logic        st;
		logic        rnd;
		logic [15:0] pk;
		logic [15:0] r;
		sg = a[15] ^ b[15];
		r = 16'd0;
		if (h_isnan(a) || h_isnan(b)) begin
			r = HALF_QNAN;
		end else if (h_isinf(a) || h_isinf(b)) begin
			r = (h_iszero(a) || h_iszero(b)) ? HALF_QNAN : {sg, HALF_INF_MAG};
		end else if (h_iszero(a) || h_iszero(b)) begin
			r = {sg, 15'd0};
		end else begin
			ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
			eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
			ma = {a[14:10] != 5'd0, a[9:0]};
			mb = {b[14:10] != 5'd0, b[9:0]};
			p = ma * mb;
			z = lzc22(p);
			q = p << z;
			e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 8'sd14
				- $signed({3'b000, z});
			if (e >= 8'sd31) begin
				r = {sg, HALF_INF_MAG};
			end else begin
				n = q;
				st = 1'b0;
				if (e < 8'sd1) begin
					sh = 7'(8'sd1 - e);
					if (sh >= 7'd23) begin
						n = 22'd0;
						st = 1'b1;
					end else begin
						w = {q, 23'd0} >> sh;
						n = w[44:23];
						st = w[22:0] != 23'd0;
					end
				end
				st = st | (n[9:0] != 10'd0);
				rnd = n[10] & (st | n[11]);
				pk = {1'b0, ((e >= 8'sd1) ? e[4:0] : 5'd0), n[20:11]} + {15'd0, rnd};
				r = {sg, pk[14:0]};
			end
		end
		return r;
	endfunction

	function automatic logic signed [16:0] h_key(input logic [15:0] h);
		return h[15] ? -$signed({2'b00, h[14:0]}) : $signed({2'b00, h[14:0]});
	endfunction

	function automatic logic [15:0] h_max(input logic [15:0] a, input logic [15:0] b);
		if (h_isnan(a) || h_isnan(b)) return HALF_QNAN;
		if (h_iszero(a) && h_iszero(b)) return a & b;
		return (h_key(a) >= h_key(b)) ? a : b;
	endfunction

	function automatic logic [15:0] h_min(input logic [15:0] a, input logic [15:0] b);
		if (h_isnan(a) || h_isnan(b)) return HALF_QNAN;
		if (h_iszero(a) && h_iszero(b)) return a | b;
		return (h_key(a) <= h_key(b)) ? a : b;
	endfunction

endpackage

`default_nettype wire

>>> sv/gap_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module gap_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              vec_valid,
	input  wire gap_pkg::vec_in_t  vec,
	input  wire gap_pkg::cfg_t     cfg,
	output gap_pkg::vec8_t         red_s3,
	output logic                   red_valid_s3,
	output logic                   red_last_s3
);

	gap_pkg::vec8_t    in_vec;
	gap_pkg::vec8_t    dec_vec;
	logic [16:0]       count;
	logic [14:0]       total;
	logic [13:0]       full;
	logic [13:0]       grouped;
	logic [2:0]        part;
	logic [14:0]       pos_p1;
	logic              dec_end;
	logic              dec_merge;
	logic              dec_mask;
	gap_pkg::acc_kind_t dec_kind;

	logic [13:0]       pos_q;
	logic [15:0]       chan_q;

	logic              valid_s1;
	gap_pkg::vec8_t    v_s1;
	gap_pkg::acc_kind_t kind_s1;
	logic              merge_s1;
	logic              end_s1;
	gap_pkg::vec8_t    held_q;

	gap_pkg::vec8_t    pair_sum;
	logic              valid_s2;
	gap_pkg::vec8_t    p_s2;
	gap_pkg::acc_kind_t kind_s2;
	logic              merge_s2;
	logic              end_s2;

	gap_pkg::vec8_t    bank_a_q;
	gap_pkg::vec8_t    bank_b_q;
	gap_pkg::vec8_t    a_new;
	gap_pkg::vec8_t    b_new;
	logic              chan_last;

	assign in_vec[0] = vec.lane0;
	assign in_vec[1] = vec.lane1;
	assign in_vec[2] = vec.lane2;
	assign in_vec[3] = vec.lane3;
	assign in_vec[4] = vec.lane4;
	assign in_vec[5] = vec.lane5;
	assign in_vec[6] = vec.lane6;
	assign in_vec[7] = vec.lane7;

	// position decode against the current element count
	always_comb begin
		count = (cfg.element_count == 16'd0) ? 17'h10000 : {1'b0, cfg.element_count};
		total = 15'((count + 17'd7) >> 3);
		full = count[16:3];
		grouped = {count[16:5], 2'b00};
		part = count[2:0];
		pos_p1 = {1'b0, pos_q} + 15'd1;
		dec_end = !(pos_p1 < total);
		dec_merge = (pos_q == (grouped - 14'd1));
		dec_mask = 1'b0;
		if (pos_q < grouped) begin
			case (pos_q[1:0])
				2'd1: dec_kind = gap_pkg::K_PAIR_A;
				2'd3: dec_kind = gap_pkg::K_PAIR_B;
				default: dec_kind = gap_pkg::K_HOLD;
			endcase
		end else begin
			dec_kind = gap_pkg::K_SINGLE;
			dec_mask = (pos_q >= full) && (part != 3'd0);
		end
		for (int l = 0; l < 8; l++) begin
			dec_vec[l] = (dec_mask && (3'(l) >= part)) ? 16'd0 : in_vec[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= vec_valid;
			if (vec_valid) begin
				pos_q <= dec_end ? 14'd0 : pos_p1[13:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			v_s1 <= dec_vec;
			kind_s1 <= dec_kind;
			merge_s1 <= dec_merge;
			end_s1 <= dec_end;
			if (valid_s1 && (kind_s1 == gap_pkg::K_HOLD)) begin
				held_q <= v_s1;
			end
		end
	end

	// pair add against the held first vector
	always_comb begin
		for (int l = 0; l < 8; l++) begin
			pair_sum[l] = ((kind_s1 == gap_pkg::K_PAIR_A) || (kind_s1 == gap_pkg::K_PAIR_B))
				? gap_pkg::h_add(held_q[l], v_s1[l]) : v_s1[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s2 <= pair_sum;
			kind_s2 <= kind_s1;
			merge_s2 <= merge_s1;
			end_s2 <= end_s1;
		end
	end

	// bank update; the merge of bank b into bank a closes the grouped part
	always_comb begin
		for (int l = 0; l < 8; l++) begin
			b_new[l] = (kind_s2 == gap_pkg::K_PAIR_B)
				? gap_pkg::h_add(bank_b_q[l], p_s2[l]) : bank_b_q[l];
			case (kind_s2)
				gap_pkg::K_PAIR_A, gap_pkg::K_SINGLE: a_new[l] = gap_pkg::h_add(bank_a_q[l], p_s2[l]);
				gap_pkg::K_PAIR_B: a_new[l] = merge_s2
					? gap_pkg::h_add(bank_a_q[l], b_new[l]) : bank_a_q[l];
				default: a_new[l] = bank_a_q[l];
			endcase
		end
		chan_last = (chan_q == (cfg.channel_count - 16'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_a_q <= '0;
			bank_b_q <= '0;
			chan_q <= '0;
			red_valid_s3 <= 1'b0;
		end else if (advance) begin
			red_valid_s3 <= valid_s2 && end_s2;
			if (valid_s2) begin
				if (end_s2) begin
					bank_a_q <= '0;
					bank_b_q <= '0;
					chan_q <= chan_last ? 16'd0 : (chan_q + 16'd1);
				end else begin
					bank_a_q <= a_new;
					bank_b_q <= b_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_s3 <= a_new;
			red_last_s3 <= chan_last;
		end
	end

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_valid && advance && dec_end) |=> (pos_q == 14'd0))
		else $error("vector position not cleared after the last vector");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(pos_q) && $stable(chan_q) && $stable(bank_a_q)))
		else $error("accumulator state moved during a stall");

	a_bank_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && end_s2 && advance) |=> ((bank_a_q == '0) && (bank_b_q == '0)))
		else $error("banks not cleared at channel end");

endmodule

`default_nettype wire

>>> sv/gap_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module gap_reduce (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire gap_pkg::vec8_t   red_s3,
	input  wire logic             red_valid_s3,
	input  wire logic             red_last_s3,
	input  wire gap_pkg::cfg_t    cfg,
	output gap_pkg::res_out_t     res_q,
	output logic                  res_valid_q
);

	logic [3:0][15:0] r4_s4;
	logic [1:0][15:0] r2_s5;
	logic [15:0]      sum_s6;
	logic [15:0]      prod_s7;
	logic             valid_s4;
	logic             valid_s5;
	logic             valid_s6;
	logic             valid_s7;
	logic             last_s4;
	logic             last_s5;
	logic             last_s6;
	logic             last_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s4 <= red_valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			res_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 4; i++) begin
				r4_s4[i] <= gap_pkg::h_add(red_s3[2*i], red_s3[2*i+1]);
			end
			r2_s5[0] <= gap_pkg::h_add(r4_s4[0], r4_s4[1]);
			r2_s5[1] <= gap_pkg::h_add(r4_s4[2], r4_s4[3]);
			sum_s6 <= gap_pkg::h_add(r2_s5[0], r2_s5[1]);
			prod_s7 <= gap_pkg::h_mul(sum_s6, cfg.scale_factor);
			res_q.average <= gap_pkg::h_min(gap_pkg::h_max(prod_s7, cfg.clamp_low),
				cfg.clamp_high);
			last_s4 <= red_last_s3;
			last_s5 <= last_s4;
			last_s6 <= last_s5;
			last_s7 <= last_s6;
			res_q.last_channel <= last_s7;
		end
	end

endmodule

`default_nettype wire

>>> sv/fp16_global_average_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// channel     | direction | transfer rule
// ------------+-----------+------------------------------------------------
// vec         | in        | vec_valid & vec_ready, one 8-lane vector
// res         | out       | res_valid & res_ready, one average per channel
// cfg         | in        | cfg_we, index cfg_index, data cfg_data
//
// One vector transaction per cycle, sustained; ready drops only while the
// result register holds an untaken average.
// From the last vector of a channel to its average, the data passes the registered
// stages decode, pair add, bank add, three reduction levels, multiply and clamp.
// The whole pipeline advances on one enable, so a stall on res freezes it.
// Reset clears banks, positions, channel count and all valid bits.
module fp16_global_average_pool (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               vec_valid,
	output logic                    vec_ready,
	input  wire gap_pkg::vec_in_t   vec,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output gap_pkg::res_out_t       res
);

	gap_pkg::cfg_t  cfg_q;
	logic           advance;
	gap_pkg::vec8_t red_s3;
	logic           red_valid_s3;
	logic           red_last_s3;

	// pipeline moves unless the result register is full and not taken
	assign advance = !res_valid || res_ready;
	assign vec_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.element_count <= 16'd1;
			cfg_q.scale_factor <= 16'h3C00;
			cfg_q.clamp_low <= 16'hFC00;
			cfg_q.clamp_high <= 16'h7C00;
			cfg_q.channel_count <= 16'd1;
		end else if (cfg_we) begin
			case (gap_pkg::cfg_idx_t'(cfg_index))
				gap_pkg::CFG_ELEMENT_COUNT: cfg_q.element_count <= cfg_data;
				gap_pkg::CFG_SCALE_FACTOR:  cfg_q.scale_factor <= cfg_data;
				gap_pkg::CFG_CLAMP_LOW:     cfg_q.clamp_low <= cfg_data;
				gap_pkg::CFG_CLAMP_HIGH:    cfg_q.clamp_high <= cfg_data;
				gap_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data;
				default: ;
			endcase
		end
	end

	gap_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.vec_valid    (vec_valid),
		.vec          (vec),
		.cfg          (cfg_q),
		.red_s3       (red_s3),
		.red_valid_s3 (red_valid_s3),
		.red_last_s3  (red_last_s3)
	);

	gap_reduce u_reduce (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.red_s3       (red_s3),
		.red_valid_s3 (red_valid_s3),
		.red_last_s3  (red_last_s3),
		.cfg          (cfg_q),
		.res_q        (res),
		.res_valid_q  (res_valid)
	);

endmodule

`default_nettype wire
